// ===== hw/rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

    // action codes of an input item
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // defaults for the top-level parameters
    localparam int QUEUE_DEPTH   = 2;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd1;

    // one input item as it arrives on the pins side
    typedef struct packed {
        logic [1:0] action;
        logic [6:0] device_address;
        logic [7:0] write_data;
        logic       wide_read;
        logic       sda_in;
    } t_in_item;

    // one result item per tick
    typedef struct packed {
        logic        scl;
        logic        sda_drive_low;
        logic        busy_res;
        logic        done_res;
        logic        success;
        logic [15:0] read_data;
    } t_out_item;

    // classified request between front and engine
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] device_address;
        logic [7:0] write_data;
        logic       wide_read;
        logic       sda_in;
    } t_cmd;

    // bus phases, one SCL slot each
    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_START_A = 5'd1,
        PH_START_B = 5'd2,
        PH_START_C = 5'd3,
        PH_WBIT_LO = 5'd4,
        PH_WBIT_HI = 5'd5,
        PH_ACK_LO  = 5'd6,
        PH_ACK_HI  = 5'd7,
        PH_RS_A    = 5'd8,
        PH_RS_B    = 5'd9,
        PH_RS_C    = 5'd10,
        PH_RS_D    = 5'd11,
        PH_RBIT_LO = 5'd12,
        PH_RBIT_HI = 5'd13,
        PH_MACK_LO = 5'd14,
        PH_MACK_HI = 5'd15,
        PH_NACK_HI = 5'd16,
        PH_STOP_AH = 5'd17,
        PH_STOP_A  = 5'd18,
        PH_STOP_B  = 5'd19,
        PH_STOP_C  = 5'd20,
        PH_STOP_D  = 5'd21
    } t_phase;

    // which byte of the transaction is on the bus
    typedef enum logic [2:0] {
        ST_ADDR_W  = 3'd0,
        ST_DATA    = 3'd1,
        ST_ADDR_R  = 3'd2,
        ST_READ_HI = 3'd3,
        ST_READ_LO = 3'd4
    } t_stage;

    // queue status seen by the front and the engine
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

// ===== hw/rtl/i2cm_front.sv =====
`timescale 1ns / 1ps

module i2cm_front (
    input  logic                i_in_valid,
    input  i2cm_pkg::t_in_item  i_in_data,
    input  i2cm_pkg::t_q_status i_q_status,
    output logic                o_in_stall,
    output logic                o_push,
    output i2cm_pkg::t_cmd      o_cmd
);

    // hold the source off while the queue has no room
    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    // sort the action code, unused code counts as a plain tick
    always_comb begin
        unique case (i_in_data.action)
            i2cm_pkg::ACT_WRITE: begin
                o_cmd.kind = i2cm_pkg::KIND_WRITE;
            end
            i2cm_pkg::ACT_READ: begin
                o_cmd.kind = i2cm_pkg::KIND_READ;
            end
            default: begin
                o_cmd.kind = i2cm_pkg::KIND_TICK;
            end
        endcase
        o_cmd.device_address = i_in_data.device_address;
        o_cmd.write_data     = i_in_data.write_data;
        o_cmd.wide_read      = i_in_data.wide_read;
        o_cmd.sda_in         = i_in_data.sda_in;
    end

endmodule

// ===== hw/rtl/i2cm_queue.sv =====
`timescale 1ns / 1ps

module i2cm_queue #(
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  i2cm_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output i2cm_pkg::t_cmd      o_cmd,
    output i2cm_pkg::t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    i2cm_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;

    // pointer and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd              = r_mem[r_rd_ptr];
    assign o_status.full      = (r_count == FULL);
    assign o_status.not_empty = (r_count != '0);

endmodule

// ===== hw/rtl/i2cm_engine.sv =====
`timescale 1ns / 1ps

module i2cm_engine #(
    parameter logic [15:0] HALF_RESET = i2cm_pkg::HALF_PERIOD_RESET
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [15:0]          i_cfg_data,
    input  i2cm_pkg::t_cmd       i_cmd,
    input  i2cm_pkg::t_q_status  i_q_status,
    output logic                 o_pop,
    output logic                 o_out_valid,
    output i2cm_pkg::t_out_item  o_out_data,
    input  logic                 i_out_stall
);

    logic [15:0]          r_half;
    i2cm_pkg::t_phase     r_phase, n_phase, c_phase;
    i2cm_pkg::t_stage     r_stage, n_stage, c_stage;
    logic [3:0]           r_bit_count, n_bit_count, c_bit_count;
    logic [7:0]           r_shift, n_shift, c_shift;
    logic [15:0]          r_word, n_word, c_word;
    logic [15:0]          r_div, n_div, c_div;
    logic                 r_ack, n_ack, c_ack;
    logic                 r_is_read, c_is_read;
    logic [6:0]           r_addr, c_addr;
    logic [7:0]           r_data, c_data;
    logic                 r_wide, c_wide;
    logic                 w_start;
    logic                 w_busy;
    logic                 w_slot_end;
    logic                 w_master_acks;
    logic [3:0]           w_bit_inc;
    logic                 w_scl;
    logic                 w_low;
    logic                 w_done;
    i2cm_pkg::t_out_item  w_out;
    i2cm_pkg::t_out_item  r_out;
    logic                 r_out_valid;

    // one tick per pop, whenever an entry is queued and the output register can take it
    assign o_pop = i_q_status.not_empty && (!r_out_valid || !i_out_stall);

    // a request seen while idle loads a fresh transaction
    assign w_start = (r_phase == i2cm_pkg::PH_IDLE) && (i_cmd.kind != i2cm_pkg::KIND_TICK);

    // state as this tick sees it
    always_comb begin
        if (w_start) begin
            c_phase     = i2cm_pkg::PH_START_A;
            c_stage     = i2cm_pkg::ST_ADDR_W;
            c_bit_count = '0;
            c_shift     = '0;
            c_word      = '0;
            c_div       = '0;
            c_ack       = 1'b0;
            c_is_read   = (i_cmd.kind == i2cm_pkg::KIND_READ);
            c_addr      = i_cmd.device_address;
            c_data      = i_cmd.write_data;
            c_wide      = i_cmd.wide_read;
        end else begin
            c_phase     = r_phase;
            c_stage     = r_stage;
            c_bit_count = r_bit_count;
            c_shift     = r_shift;
            c_word      = r_word;
            c_div       = r_div;
            c_ack       = r_ack;
            c_is_read   = r_is_read;
            c_addr      = r_addr;
            c_data      = r_data;
            c_wide      = r_wide;
        end
    end

    // slot timer, a zero half period ends every tick
    assign w_busy        = (c_phase != i2cm_pkg::PH_IDLE);
    assign w_slot_end    = w_busy && (({1'b0, c_div} + 17'd1) >= {1'b0, r_half});
    assign w_master_acks = (c_stage == i2cm_pkg::ST_READ_HI) && c_wide;
    assign w_bit_inc     = c_bit_count + 4'd1;

    // pin levels of the current slot
    always_comb begin
        unique case (c_phase)
            i2cm_pkg::PH_START_A: begin w_scl = 1'b1; w_low = 1'b0; end
            i2cm_pkg::PH_START_B: begin w_scl = 1'b1; w_low = 1'b1; end
            i2cm_pkg::PH_START_C: begin w_scl = 1'b0; w_low = 1'b1; end
            i2cm_pkg::PH_WBIT_LO: begin w_scl = 1'b0; w_low = !c_shift[7]; end
            i2cm_pkg::PH_WBIT_HI: begin w_scl = 1'b1; w_low = !c_shift[7]; end
            i2cm_pkg::PH_ACK_LO:  begin w_scl = 1'b0; w_low = 1'b0; end
            i2cm_pkg::PH_ACK_HI:  begin w_scl = 1'b1; w_low = 1'b0; end
            i2cm_pkg::PH_RS_A:    begin w_scl = 1'b0; w_low = 1'b0; end
            i2cm_pkg::PH_RS_B:    begin w_scl = 1'b1; w_low = 1'b0; end
            i2cm_pkg::PH_RS_C:    begin w_scl = 1'b1; w_low = 1'b1; end
            i2cm_pkg::PH_RS_D:    begin w_scl = 1'b0; w_low = 1'b1; end
            i2cm_pkg::PH_RBIT_LO: begin w_scl = 1'b0; w_low = 1'b0; end
            i2cm_pkg::PH_RBIT_HI: begin w_scl = 1'b1; w_low = 1'b0; end
            i2cm_pkg::PH_MACK_LO: begin w_scl = 1'b0; w_low = w_master_acks; end
            i2cm_pkg::PH_MACK_HI: begin w_scl = 1'b1; w_low = w_master_acks; end
            i2cm_pkg::PH_NACK_HI: begin w_scl = 1'b1; w_low = 1'b0; end
            i2cm_pkg::PH_STOP_AH: begin w_scl = 1'b1; w_low = 1'b1; end
            i2cm_pkg::PH_STOP_A:  begin w_scl = 1'b0; w_low = 1'b1; end
            i2cm_pkg::PH_STOP_B:  begin w_scl = 1'b0; w_low = 1'b1; end
            i2cm_pkg::PH_STOP_C:  begin w_scl = 1'b1; w_low = 1'b1; end
            i2cm_pkg::PH_STOP_D:  begin w_scl = 1'b1; w_low = 1'b0; end
            default:              begin w_scl = 1'b1; w_low = 1'b0; end
        endcase
    end

    // result of this tick
    assign w_done = w_slot_end && (c_phase == i2cm_pkg::PH_STOP_D);
    always_comb begin
        w_out.scl           = w_scl;
        w_out.sda_drive_low = w_low;
        w_out.busy_res      = w_busy;
        w_out.done_res      = w_done;
        w_out.success       = w_done && c_ack;
        w_out.read_data     = (w_done && c_ack && c_is_read) ? c_word : 16'd0;
    end

    // next state at the end of a slot
    always_comb begin
        n_phase     = c_phase;
        n_stage     = c_stage;
        n_bit_count = c_bit_count;
        n_shift     = c_shift;
        n_word      = c_word;
        n_ack       = c_ack;
        n_div       = c_div;
        if (w_busy) begin
            n_div = w_slot_end ? 16'd0 : c_div + 16'd1;
        end
        if (w_slot_end) begin
            unique case (c_phase)
                i2cm_pkg::PH_START_A: n_phase = i2cm_pkg::PH_START_B;
                i2cm_pkg::PH_START_B: n_phase = i2cm_pkg::PH_START_C;
                i2cm_pkg::PH_START_C: begin
                    n_shift     = {c_addr, 1'b0};
                    n_bit_count = '0;
                    n_phase     = i2cm_pkg::PH_WBIT_LO;
                end
                i2cm_pkg::PH_WBIT_LO: n_phase = i2cm_pkg::PH_WBIT_HI;
                i2cm_pkg::PH_WBIT_HI: begin
                    n_shift     = {c_shift[6:0], 1'b0};
                    n_bit_count = w_bit_inc;
                    n_phase     = w_bit_inc[3] ? i2cm_pkg::PH_ACK_LO : i2cm_pkg::PH_WBIT_LO;
                end
                i2cm_pkg::PH_ACK_LO: n_phase = i2cm_pkg::PH_ACK_HI;
                i2cm_pkg::PH_ACK_HI: begin
                    if (c_stage == i2cm_pkg::ST_DATA) begin
                        // data ack of a write is not checked
                        n_phase = i2cm_pkg::PH_STOP_A;
                    end else begin
                        n_ack = !i_cmd.sda_in;
                        if (i_cmd.sda_in) begin
                            n_phase = (c_stage == i2cm_pkg::ST_ADDR_W && !c_is_read)
                                    ? i2cm_pkg::PH_NACK_HI : i2cm_pkg::PH_STOP_A;
                        end else if (c_stage == i2cm_pkg::ST_ADDR_W) begin
                            if (!c_is_read) begin
                                n_stage     = i2cm_pkg::ST_DATA;
                                n_shift     = c_data;
                                n_bit_count = '0;
                                n_phase     = i2cm_pkg::PH_WBIT_LO;
                            end else begin
                                n_phase = i2cm_pkg::PH_RS_A;
                            end
                        end else begin
                            n_stage     = i2cm_pkg::ST_READ_HI;
                            n_bit_count = '0;
                            n_word      = '0;
                            n_phase     = i2cm_pkg::PH_RBIT_LO;
                        end
                    end
                end
                i2cm_pkg::PH_RS_A: n_phase = i2cm_pkg::PH_RS_B;
                i2cm_pkg::PH_RS_B: n_phase = i2cm_pkg::PH_RS_C;
                i2cm_pkg::PH_RS_C: n_phase = i2cm_pkg::PH_RS_D;
                i2cm_pkg::PH_RS_D: begin
                    n_stage     = i2cm_pkg::ST_ADDR_R;
                    n_shift     = {c_addr, 1'b1};
                    n_bit_count = '0;
                    n_phase     = i2cm_pkg::PH_WBIT_LO;
                end
                i2cm_pkg::PH_RBIT_LO: n_phase = i2cm_pkg::PH_RBIT_HI;
                i2cm_pkg::PH_RBIT_HI: begin
                    n_word      = {c_word[14:0], i_cmd.sda_in};
                    n_bit_count = w_bit_inc;
                    n_phase     = w_bit_inc[3] ? i2cm_pkg::PH_MACK_LO : i2cm_pkg::PH_RBIT_LO;
                end
                i2cm_pkg::PH_MACK_LO: n_phase = i2cm_pkg::PH_MACK_HI;
                i2cm_pkg::PH_MACK_HI: begin
                    if (w_master_acks) begin
                        n_stage     = i2cm_pkg::ST_READ_LO;
                        n_bit_count = '0;
                        n_phase     = i2cm_pkg::PH_RBIT_LO;
                    end else begin
                        n_phase = i2cm_pkg::PH_STOP_A;
                    end
                end
                i2cm_pkg::PH_NACK_HI: n_phase = i2cm_pkg::PH_STOP_AH;
                i2cm_pkg::PH_STOP_AH: n_phase = i2cm_pkg::PH_STOP_B;
                i2cm_pkg::PH_STOP_A:  n_phase = i2cm_pkg::PH_STOP_B;
                i2cm_pkg::PH_STOP_B:  n_phase = i2cm_pkg::PH_STOP_C;
                i2cm_pkg::PH_STOP_C:  n_phase = i2cm_pkg::PH_STOP_D;
                default:              n_phase = i2cm_pkg::PH_IDLE;
            endcase
        end
    end

    // half period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RESET;
        end else if (i_cfg_valid) begin
            r_half <= i_cfg_data;
        end
    end

    // transaction state, advanced once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cm_pkg::PH_IDLE;
            r_stage     <= i2cm_pkg::ST_ADDR_W;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_word      <= '0;
            r_div       <= '0;
            r_ack       <= 1'b0;
            r_is_read   <= 1'b0;
        end else if (o_pop) begin
            r_phase     <= n_phase;
            r_stage     <= n_stage;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_word      <= n_word;
            r_div       <= n_div;
            r_ack       <= n_ack;
            r_is_read   <= c_is_read;
        end
    end

    // latched request fields
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr <= c_addr;
            r_data <= c_data;
            r_wide <= c_wide;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_success_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.success |-> r_out.done_res)
        else $error("success without done");

    a_data_needs_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.read_data != 16'd0) |-> r_out.success && r_out.busy_res)
        else $error("read data on a failed or idle tick");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && w_out.done_res |=> r_phase == i2cm_pkg::PH_IDLE)
        else $error("engine not idle after done");

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= 4'd8)
        else $error("bit count past one byte");

endmodule

// ===== hw/rtl/i2c_master_register_access.sv =====
`timescale 1ns / 1ps

// Single-master I2C transaction engine, one bus tick per input request and
// exactly one result request per tick. A request with a write or read action
// while idle starts a transaction; requests that arrive while it runs count
// as plain ticks. The block sustains one request per clock while the output
// is not stalled: the front sorts each request into a small queue and the
// engine retires one tick per clock whenever the output register can take it.
// A request is written into the queue when it is taken, and its result moves
// from there into the output register when the engine pops it; the pop waits
// while the output is stalled. The half period register is written through
// the cfg channel, which is always ready; write it only while the block is idle.
module i2c_master_register_access #(
    parameter int          QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH,
    parameter logic [15:0] HALF_RESET  = i2cm_pkg::HALF_PERIOD_RESET
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    input  i2cm_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output i2cm_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);

    i2cm_pkg::t_q_status w_q_status;
    i2cm_pkg::t_cmd      w_push_cmd;
    i2cm_pkg::t_cmd      w_head_cmd;
    logic                w_push;
    logic                w_pop;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    // front: accept and classify
    i2cm_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_status (w_q_status),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // queue between front and engine
    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    // engine: bus phases and result register
    i2cm_engine #(
        .HALF_RESET (HALF_RESET)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_head_cmd),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== tb/i2c_master_register_access_tb.sv =====
`timescale 1ns / 1ps

module i2c_master_register_access_tb;

    import i2cm_pkg::*;

    // action code with no meaning of its own, taken as a plain tick
    localparam logic [1:0] ACT_SPARE     = 2'd3;
    localparam int         BITS_PER_BYTE = 8;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         RANDOM_BUDGET = 36;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_data   = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic        i_out_stall = 1'b0;

    // bus engine state as the testbench sees it
    logic [15:0] half_ticks = 16'd1;
    t_phase      ph         = PH_IDLE;
    t_stage      stg        = ST_ADDR_W;
    logic [3:0]  bits       = '0;
    logic [7:0]  shreg      = '0;
    logic [15:0] rword      = '0;
    logic [15:0] slot_ticks = '0;
    logic        acked      = 1'b0;
    logic [1:0]  req_act    = ACT_TICK;
    logic [6:0]  req_addr   = '0;
    logic [7:0]  req_data   = '0;
    logic        req_wide   = 1'b0;

    t_out_item   expected_ticks[$];
    t_out_item   oldest;
    int          send_gap_pct   = 0;
    int          sink_stall_pct = 0;
    int          sent_count     = 0;
    int          results_seen   = 0;
    int          mismatches     = 0;
    int          quiet_cycles   = 0;

    i2c_master_register_access dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // master acks the first byte only when two bytes are read
    function automatic logic reading_first_of_two();
        return (stg == ST_READ_HI) && req_wide;
    endfunction

    // scl and sda pull-down held for the whole slot
    function automatic logic [1:0] slot_pins();
        case (ph)
            PH_START_A: return 2'b10;
            PH_START_B: return 2'b11;
            PH_START_C: return 2'b01;
            PH_WBIT_LO: return {1'b0, ~shreg[7]};
            PH_WBIT_HI: return {1'b1, ~shreg[7]};
            PH_ACK_LO:  return 2'b00;
            PH_ACK_HI:  return 2'b10;
            PH_RS_A:    return 2'b00;
            PH_RS_B:    return 2'b10;
            PH_RS_C:    return 2'b11;
            PH_RS_D:    return 2'b01;
            PH_RBIT_LO: return 2'b00;
            PH_RBIT_HI: return 2'b10;
            PH_MACK_LO: return {1'b0, reading_first_of_two()};
            PH_MACK_HI: return {1'b1, reading_first_of_two()};
            PH_NACK_HI: return 2'b10;
            PH_STOP_AH: return 2'b11;
            PH_STOP_A:  return 2'b01;
            PH_STOP_B:  return 2'b01;
            PH_STOP_C:  return 2'b11;
            PH_STOP_D:  return 2'b10;
            default:    return 2'b10;
        endcase
    endfunction

    function automatic void load_byte(input logic [7:0] value);
        shreg = value;
        bits  = '0;
        ph    = PH_WBIT_LO;
    endfunction

    // end of a slot: step the phase, true when the transaction is over
    function automatic logic close_slot(input logic sda);
        case (ph)
            PH_START_A: ph = PH_START_B;
            PH_START_B: ph = PH_START_C;
            PH_START_C: load_byte({req_addr, 1'b0});
            PH_WBIT_LO: ph = PH_WBIT_HI;
            PH_WBIT_HI: begin
                shreg = {shreg[6:0], 1'b0};
                bits  = bits + 4'd1;
                ph    = (bits >= BITS_PER_BYTE) ? PH_ACK_LO : PH_WBIT_LO;
            end
            PH_ACK_LO:  ph = PH_ACK_HI;
            PH_ACK_HI: begin
                if (stg == ST_DATA) begin
                    ph = PH_STOP_A;
                end else begin
                    acked = (sda == 1'b0);
                    if (!acked) begin
                        ph = (stg == ST_ADDR_W && req_act == ACT_WRITE) ? PH_NACK_HI
                                                                       : PH_STOP_A;
                    end else if (stg == ST_ADDR_W) begin
                        if (req_act == ACT_WRITE) begin
                            stg = ST_DATA;
                            load_byte(req_data);
                        end else begin
                            ph = PH_RS_A;
                        end
                    end else begin
                        stg   = ST_READ_HI;
                        bits  = '0;
                        rword = '0;
                        ph    = PH_RBIT_LO;
                    end
                end
            end
            PH_RS_A:    ph = PH_RS_B;
            PH_RS_B:    ph = PH_RS_C;
            PH_RS_C:    ph = PH_RS_D;
            PH_RS_D: begin
                stg = ST_ADDR_R;
                load_byte({req_addr, 1'b1});
            end
            PH_RBIT_LO: ph = PH_RBIT_HI;
            PH_RBIT_HI: begin
                rword = {rword[14:0], sda};
                bits  = bits + 4'd1;
                ph    = (bits >= BITS_PER_BYTE) ? PH_MACK_LO : PH_RBIT_LO;
            end
            PH_MACK_LO: ph = PH_MACK_HI;
            PH_MACK_HI: begin
                if (reading_first_of_two()) begin
                    stg  = ST_READ_LO;
                    bits = '0;
                    ph   = PH_RBIT_LO;
                end else begin
                    ph = PH_STOP_A;
                end
            end
            PH_NACK_HI: ph = PH_STOP_AH;
            PH_STOP_AH: ph = PH_STOP_B;
            PH_STOP_A:  ph = PH_STOP_B;
            PH_STOP_B:  ph = PH_STOP_C;
            PH_STOP_C:  ph = PH_STOP_D;
            PH_STOP_D: begin
                ph = PH_IDLE;
                return 1'b1;
            end
            default:    ph = PH_IDLE;
        endcase
        return 1'b0;
    endfunction

    // one bus tick: work out the pins and status it produces
    task automatic advance_bus_tick(input t_in_item it);
        t_out_item   want;
        logic [16:0] span;
        want     = '0;
        want.scl = 1'b1;
        if (ph == PH_IDLE && (it.action == ACT_WRITE || it.action == ACT_READ)) begin
            req_act    = it.action;
            req_addr   = it.device_address;
            req_data   = it.write_data;
            req_wide   = it.wide_read;
            ph         = PH_START_A;
            stg        = ST_ADDR_W;
            slot_ticks = '0;
            bits       = '0;
            shreg      = '0;
            rword      = '0;
            acked      = 1'b0;
        end
        if (ph != PH_IDLE) begin
            span = (half_ticks == '0) ? 17'd1 : {1'b0, half_ticks};
            want.busy_res = 1'b1;
            {want.scl, want.sda_drive_low} = slot_pins();
            if ({1'b0, slot_ticks} + 17'd1 >= span) begin
                slot_ticks = '0;
                if (close_slot(it.sda_in)) begin
                    want.done_res  = 1'b1;
                    want.success   = acked;
                    want.read_data = (acked && req_act == ACT_READ) ? rword : '0;
                end
            end else begin
                slot_ticks = slot_ticks + 16'd1;
            end
        end
        expected_ticks.push_back(want);
    endtask

    // what a well-behaved slave puts on sda for the coming tick
    function automatic logic slave_level(input logic addr_nack, input logic late_nack,
                                         input logic [15:0] word);
        logic [7:0] rd_byte;
        int         idx;
        if (ph == PH_ACK_HI) begin
            if (stg == ST_ADDR_W) return addr_nack;
            return late_nack;
        end
        if (ph == PH_RBIT_HI) begin
            rd_byte = (stg == ST_READ_HI && req_wide) ? word[15:8] : word[7:0];
            idx     = BITS_PER_BYTE - 1 - int'(bits);
            return rd_byte[idx];
        end
        return 1'($urandom_range(1));
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.action         = 2'($urandom_range(ACT_SPARE));
        it.device_address = 7'($urandom_range(127));
        it.write_data     = 8'($urandom_range(255));
        it.wide_read      = 1'($urandom_range(1));
        it.sda_in         = 1'($urandom_range(1));
        return it;
    endfunction

    // offer one request and wait until it is taken
    task automatic send_tick(input t_in_item it);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        advance_bus_tick(it);
        sent_count++;
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    // let the block drain, then load a new half period
    task automatic write_half_period(input logic [15:0] value);
        stop_sending();
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        half_ticks = value;
    endtask

    // start one transaction and tick it through to its stop condition
    task automatic run_transfer(input logic [1:0] act, input logic [6:0] addr,
                                input logic [7:0] data, input logic wide,
                                input logic addr_nack, input logic late_nack,
                                input logic [15:0] word, input int junk_pct);
        t_in_item it;
        it                = random_item();
        it.action         = act;
        it.device_address = addr;
        it.write_data     = data;
        it.wide_read      = wide;
        send_tick(it);
        while (ph != PH_IDLE) begin
            it = random_item();
            if ($urandom_range(99) >= junk_pct) it.action = ACT_TICK;
            it.sda_in = slave_level(addr_nack, late_nack, word);
            send_tick(it);
        end
    endtask

    // plain and spare ticks with the fields at their extremes
    task automatic test_idle_ticks();
        t_in_item it;
        logic     ext;
        for (int i = 0; i < 4; i++) begin
            ext               = (i == 1 || i == 2);
            it.action         = (i % 2 == 1) ? ACT_SPARE : ACT_TICK;
            it.device_address = {7{ext}};
            it.write_data     = {8{ext}};
            it.wide_read      = ext;
            it.sda_in         = ext;
            send_tick(it);
        end
    endtask

    task automatic test_write_addr_nack();
        run_transfer(ACT_WRITE, 7'h00, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 0);
    endtask

    // data ack is not checked, so a nack there still ends in success
    task automatic test_write_data();
        run_transfer(ACT_WRITE, 7'h7F, 8'hFF, 1'b1, 1'b0, 1'b1, 16'h0000, 0);
        run_transfer(ACT_WRITE, 7'h2A, 8'h5A, 1'b0, 1'b0, 1'b0, 16'h0000, 0);
    endtask

    task automatic test_read_nacks();
        run_transfer(ACT_READ, 7'h13, 8'h00, 1'b1, 1'b1, 1'b0, 16'hFFFF, 0);
        run_transfer(ACT_READ, 7'h64, 8'h00, 1'b1, 1'b0, 1'b1, 16'hFFFF, 0);
    endtask

    task automatic test_read_bytes();
        run_transfer(ACT_READ, 7'h55, 8'h00, 1'b0, 1'b0, 1'b0, 16'h00A5, 0);
        run_transfer(ACT_READ, 7'h7F, 8'hFF, 1'b1, 1'b0, 1'b0, 16'hFFFF, 0);
        run_transfer(ACT_READ, 7'h00, 8'h00, 1'b1, 1'b0, 1'b0, 16'h1234, 0);
    endtask

    // new requests that land mid-transaction must be ignored
    task automatic test_busy_requests();
        run_transfer(ACT_WRITE, 7'h31, 8'hC6, 1'b0, 1'b0, 1'b0, 16'h0000, 100);
        run_transfer(ACT_READ, 7'h4E, 8'h39, 1'b1, 1'b0, 1'b0, 16'h8001, 100);
    endtask

    task automatic test_zero_half_period();
        write_half_period(16'h0000);
        run_transfer(ACT_READ, 7'h21, 8'h00, 1'b1, 1'b0, 1'b0, 16'hC33C, 0);
    endtask

    // longer slots, then the largest setting while idle
    task automatic test_slow_slots();
        t_in_item it;
        write_half_period(16'd3);
        run_transfer(ACT_WRITE, 7'h0F, 8'hA5, 1'b0, 1'b1, 1'b0, 16'h0000, 0);
        run_transfer(ACT_READ, 7'h70, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 0);
        write_half_period(16'hFFFF);
        repeat (6) begin
            it        = random_item();
            it.action = $urandom_range(1) ? ACT_SPARE : ACT_TICK;
            send_tick(it);
        end
    endtask

    // mostly well-formed transactions, some noise that may start broken ones
    task automatic mix_until(input int stop_at);
        t_in_item it;
        while (sent_count < stop_at) begin
            if ($urandom_range(99) < 85) begin
                run_transfer($urandom_range(1) ? ACT_READ : ACT_WRITE,
                             7'($urandom_range(127)), 8'($urandom_range(255)),
                             1'($urandom_range(1)), $urandom_range(99) < 10,
                             $urandom_range(99) < 10, 16'($urandom_range(16'hFFFF)), 20);
            end else begin
                repeat ($urandom_range(12, 1)) send_tick(random_item());
                while (ph != PH_IDLE) send_tick(random_item());
            end
        end
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct);
        logic [15:0] alt_half;
        send_gap_pct   = gap_pct;
        sink_stall_pct = stall_pct;
        write_half_period(16'd1);
        mix_until(sent_count + RANDOM_BUDGET * 2 / 3);
        case ($urandom_range(1))
            0:       alt_half = 16'd0;
            default: alt_half = 16'd2;
        endcase
        write_half_period(alt_half);
        mix_until(sent_count + RANDOM_BUDGET / 3);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        $display("result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    endtask

    // check each result against the oldest expected tick, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_ticks.size() == 0) begin
                report_mismatch("result with nothing outstanding", '0, '0);
            end else begin
                oldest = expected_ticks.pop_front();
                if (o_out_data.scl !== oldest.scl)
                    report_mismatch("scl", 16'(o_out_data.scl), 16'(oldest.scl));
                if (o_out_data.sda_drive_low !== oldest.sda_drive_low)
                    report_mismatch("sda_drive_low", 16'(o_out_data.sda_drive_low),
                                    16'(oldest.sda_drive_low));
                if (o_out_data.busy_res !== oldest.busy_res)
                    report_mismatch("busy_res", 16'(o_out_data.busy_res),
                                    16'(oldest.busy_res));
                if (o_out_data.done_res !== oldest.done_res)
                    report_mismatch("done_res", 16'(o_out_data.done_res),
                                    16'(oldest.done_res));
                if (o_out_data.success !== oldest.success)
                    report_mismatch("success", 16'(o_out_data.success),
                                    16'(oldest.success));
                if (o_out_data.read_data !== oldest.read_data)
                    report_mismatch("read_data", o_out_data.read_data, oldest.read_data);
            end
            results_seen++;
        end
        i_out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
    end

    // watchdog on cycles where no channel moves anything
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // test sequence
    initial begin
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct   = 12;
        sink_stall_pct = 48;
        test_idle_ticks();
        test_write_addr_nack();
        test_write_data();
        test_read_nacks();
        test_read_bytes();
        test_busy_requests();
        test_zero_half_period();
        test_slow_slots();
        test_random_traffic(12, 48);
        test_random_traffic(48, 12);
        test_random_traffic(0, 0);
        stop_sending();
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== i2c_master_register_access.f =====
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_queue.sv
hw/rtl/i2cm_engine.sv
hw/rtl/i2c_master_register_access.sv
tb/i2c_master_register_access_tb.sv
